@@ rtl/swss_pkg.sv @@
// ----------------------------------------------------------------------------
// swss_pkg: stopwatch types, constants and segment decoding
// Shared definitions for the stopwatch with button control and a four-digit
// seven-segment display: payload structs, limits and the digit decoder.
// ----------------------------------------------------------------------------
package swss_pkg;

  localparam int NUM_DIGITS = 4;

  localparam logic [13:0] COUNT_MAX        = 14'd9999;
  localparam logic [13:0] TENS_LIMIT       = 14'd999;
  localparam logic [7:0]  HOLD_MAX         = 8'd255;
  localparam logic [7:0]  LONG_PRESS_RESET = 8'd150;
  localparam logic [7:0]  LONG_PRESS_MIN   = 8'd1;
  localparam logic [3:0]  BCD_NINE         = 4'd9;
  localparam logic [3:0]  DIGIT_EN_LOW     = 4'd7;
  localparam logic [3:0]  DIGIT_EN_HIGH    = 4'd15;
  localparam logic [3:0]  POINT_ONES       = 4'd4;

  typedef logic [6:0] seg_t;
  typedef logic [NUM_DIGITS-1:0][3:0] bcd_digits_t;

  typedef struct packed {
    logic button_level;
  } tick_t;

  typedef struct packed {
    logic [13:0] count_value;
    seg_t        seg_hundredths;
    seg_t        seg_tenths;
    seg_t        seg_ones;
    seg_t        seg_tens;
    logic [3:0]  digit_enable;
    logic [3:0]  point_mask;
    logic        is_running;
    logic        overflowed;
  } result_t;

  // Active-high segments, bit0 = a ... bit6 = g
  function automatic seg_t seg_decode(input logic [3:0] digit);
    seg_t code;
    case (digit)
      4'd0: code = 7'h3F;
      4'd1: code = 7'h06;
      4'd2: code = 7'h5B;
      4'd3: code = 7'h4F;
      4'd4: code = 7'h66;
      4'd5: code = 7'h6D;
      4'd6: code = 7'h7D;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7F;
      4'd9: code = 7'h67;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/swss_if.sv @@
// ----------------------------------------------------------------------------
// swss_if: valid/ready channels of the stopwatch
// Tick channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface swss_in_if;
  logic            valid;
  logic            ready;
  swss_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swss_out_if;
  logic              valid;
  logic              ready;
  swss_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/stopwatch_button_seven_segment.sv @@
// ----------------------------------------------------------------------------
// stopwatch_button_seven_segment: one-button stopwatch with 7-segment output
// A tick transaction accepted at one edge shows its result on the next cycle.
// Throughput: one tick per cycle, set by the single state update feeding the
// result register; a stalled result only holds the input off.
// Reset (synchronous, rst high): count zero, stopped, no overflow, button
// released, long press threshold 150, result register empty.
// ----------------------------------------------------------------------------
module stopwatch_button_seven_segment (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  swss_in_if.sink    ticks,
  swss_out_if.source results
);

  // Configuration: long press threshold in ticks
  logic [7:0] long_press_ticks;
  logic [7:0] thr;

  // Stopwatch state. The count is kept both in binary (for the limit
  // compares and the count output) and as BCD digits (for the display),
  // so no division is ever needed.
  logic [13:0]           count;
  logic [13:0]           count_next;
  swss_pkg::bcd_digits_t digits;
  swss_pkg::bcd_digits_t digits_next;
  logic                  run;
  logic                  run_next;
  logic                  ovf;
  logic                  ovf_next;
  logic [7:0]            hold;
  logic [7:0]            hold_next;
  logic                  long_done;
  logic                  long_done_next;
  logic                  prev_button;
  logic                  carry;

  // Result register
  logic              out_valid;
  swss_pkg::result_t result;
  swss_pkg::result_t result_next;

  logic accept;

  // Take a new tick whenever the result register is empty or being drained
  assign ticks.ready = !out_valid || results.ready;
  assign accept      = ticks.valid && ticks.ready;

  assign results.valid = out_valid;
  assign results.data  = result;

  // A zero threshold behaves as one: any press is long on its first tick
  assign thr = (long_press_ticks == '0) ? swss_pkg::LONG_PRESS_MIN : long_press_ticks;

  // Tick update: advance the count with the run flag as it stood, then
  // handle the button, all in one pass.
  always_comb begin
    count_next     = count;
    digits_next    = digits;
    run_next       = run;
    ovf_next       = ovf;
    hold_next      = hold;
    long_done_next = long_done;
    carry          = 1'b1;

    if (run) begin
      if (count < swss_pkg::COUNT_MAX) begin
        count_next = count + 14'd1;
        // Ripple the increment through the BCD digits
        for (int i = 0; i < swss_pkg::NUM_DIGITS; i++) begin
          if (carry) begin
            if (digits[i] == swss_pkg::BCD_NINE) begin
              digits_next[i] = 4'd0;
            end else begin
              digits_next[i] = digits[i] + 4'd1;
              carry          = 1'b0;
            end
          end
        end
      end else begin
        // Saturate: hold 9999, flag overflow and stop
        ovf_next = 1'b1;
        run_next = 1'b0;
      end
    end

    if (ticks.data.button_level) begin
      if (hold < swss_pkg::HOLD_MAX) begin
        hold_next = hold + 8'd1;
      end
      // Long press: clear the count and overflow and stop, once per press
      if (!long_done && (hold_next >= thr)) begin
        count_next     = '0;
        digits_next    = '0;
        run_next       = 1'b0;
        ovf_next       = 1'b0;
        long_done_next = 1'b1;
      end
    end else if (prev_button) begin
      // Release: a short press toggles run/stop, a long one leaves it stopped
      if (!long_done) begin
        run_next = !run_next;
      end
      hold_next      = '0;
      long_done_next = 1'b0;
    end
  end

  // Form the result from the updated state
  always_comb begin
    result_next.count_value    = count_next;
    result_next.seg_hundredths = swss_pkg::seg_decode(digits_next[0]);
    result_next.seg_tenths     = swss_pkg::seg_decode(digits_next[1]);
    result_next.seg_ones       = swss_pkg::seg_decode(digits_next[2]);
    result_next.seg_tens       = swss_pkg::seg_decode(digits_next[3]);
    result_next.digit_enable   = (count_next > swss_pkg::TENS_LIMIT) ?
                                 swss_pkg::DIGIT_EN_HIGH : swss_pkg::DIGIT_EN_LOW;
    result_next.point_mask     = swss_pkg::POINT_ONES;
    result_next.is_running     = run_next;
    result_next.overflowed     = ovf_next;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= swss_pkg::LONG_PRESS_RESET;
      count            <= '0;
      digits           <= '0;
      run              <= 1'b0;
      ovf              <= 1'b0;
      hold             <= '0;
      long_done        <= 1'b0;
      prev_button      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_ticks <= cfg_data;
      end
      if (accept) begin
        count       <= count_next;
        digits      <= digits_next;
        run         <= run_next;
        ovf         <= ovf_next;
        hold        <= hold_next;
        long_done   <= long_done_next;
        prev_button <= ticks.data.button_level;
        out_valid   <= 1'b1;
      end else if (results.ready) begin
        // Drop the result once the sink has taken it
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted tick, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/swss_checker.sv @@
// ----------------------------------------------------------------------------
// swss_checker: port-level checks for the stopwatch
// Watches the channels of the top level and flags broken behaviour.
// ----------------------------------------------------------------------------
module swss_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swss_pkg::result_t out_data
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // A full, stalled result register takes no new tick
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("tick taken while result stalled");

  // Overflow only ever stands with a saturated count
  a_ovf_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflowed |-> out_data.count_value == swss_pkg::COUNT_MAX)
    else $error("overflow flagged below the limit");

  // The tens digit is lit exactly from 1000 up
  a_digit_en: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.digit_enable == swss_pkg::DIGIT_EN_HIGH) ==
                   (out_data.count_value > swss_pkg::TENS_LIMIT)))
    else $error("digit enable does not match count");

endmodule

bind stopwatch_button_seven_segment swss_checker u_swss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (ticks.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
